// ----- rtl/core/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared constants and types of the letterbox scaler: frame store geometry,
// active area sizes, operation and register codes, request bundle.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int COORD_W = 9;
  localparam int COLOR_W = 8;
  localparam int PIX_W   = 16;

  localparam int SRC_W  = 320;
  localparam int SRC_H  = 240;
  localparam int DEPTH  = SRC_W * SRC_H;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int ACT_W_WIDE   = 320;
  localparam int ACT_W_NARROW = 256;
  localparam int ACT_H_TALL   = 240;
  localparam int ACT_H_SHORT  = 224;

  localparam int TOP_TALL  = (SRC_H - ACT_H_TALL) / 2;
  localparam int TOP_SHORT = (SRC_H - ACT_H_SHORT) / 2;

  localparam int SX_W   = 9;
  localparam int LINE_W = 8;

  localparam int RED_LSB   = 11;
  localparam int GREEN_LSB = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TALL = 1'b1;

  localparam int OUT_W_DEFAULT = 480;
  localparam int OUT_H_DEFAULT = 320;

  typedef struct packed {
    logic              is_read;
    logic              active;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } lbs_req_t;

endpackage

// ----- rtl/core/lbs_map.sv -----
// ----------------------------------------------------------------------------
// lbs_map
// Coordinate mapping. Stage A checks the screen pixel against the letterbox
// and multiplies the offsets by fixed-point reciprocals; stage B forms the
// frame store address of a read or a write.
// ----------------------------------------------------------------------------
module lbs_map
  import lbs_pkg::*;
#(
  parameter int OUT_W = OUT_W_DEFAULT,
  parameter int OUT_H = OUT_H_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wide_mode,
  input  logic               tall_mode,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  output logic               req_valid,
  input  logic               req_ready,
  output lbs_req_t           req
);

  function automatic longint max2(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  localparam int XW = (COORD_W > $clog2(OUT_W + 1)) ? COORD_W : $clog2(OUT_W + 1);
  localparam int YW = (COORD_W > $clog2(OUT_H + 1)) ? COORD_W : $clog2(OUT_H + 1);
  localparam int KX = 2 * $clog2(OUT_W);
  localparam int KY = 2 * $clog2(OUT_H);

  // mode 0: 256x224, 1: 256x240, 2: 320x224, 3: 320x240
  localparam longint SWR0 = longint'(ACT_W_NARROW) * OUT_H / ACT_H_SHORT;
  localparam longint SWR1 = longint'(ACT_W_NARROW) * OUT_H / ACT_H_TALL;
  localparam longint SWR2 = longint'(ACT_W_WIDE) * OUT_H / ACT_H_SHORT;
  localparam longint SWR3 = longint'(ACT_W_WIDE) * OUT_H / ACT_H_TALL;
  localparam longint SW0 = (SWR0 > OUT_W) ? OUT_W : SWR0;
  localparam longint SW1 = (SWR1 > OUT_W) ? OUT_W : SWR1;
  localparam longint SW2 = (SWR2 > OUT_W) ? OUT_W : SWR2;
  localparam longint SW3 = (SWR3 > OUT_W) ? OUT_W : SWR3;
  localparam longint SH0 = SW0 * ACT_H_SHORT / ACT_W_NARROW;
  localparam longint SH1 = SW1 * ACT_H_TALL / ACT_W_NARROW;
  localparam longint SH2 = SW2 * ACT_H_SHORT / ACT_W_WIDE;
  localparam longint SH3 = SW3 * ACT_H_TALL / ACT_W_WIDE;
  localparam longint OX0 = (OUT_W - SW0) / 2;
  localparam longint OX1 = (OUT_W - SW1) / 2;
  localparam longint OX2 = (OUT_W - SW2) / 2;
  localparam longint OX3 = (OUT_W - SW3) / 2;
  localparam longint OY0 = (OUT_H - SH0) / 2;
  localparam longint OY1 = (OUT_H - SH1) / 2;
  localparam longint OY2 = (OUT_H - SH2) / 2;
  localparam longint OY3 = (OUT_H - SH3) / 2;

  // ceil(act * 2^K / scale): floor of the product shifted by K is exact
  localparam longint RX0 = (longint'(ACT_W_NARROW) * (longint'(1) << KX) + SW0 - 1) / SW0;
  localparam longint RX1 = (longint'(ACT_W_NARROW) * (longint'(1) << KX) + SW1 - 1) / SW1;
  localparam longint RX2 = (longint'(ACT_W_WIDE) * (longint'(1) << KX) + SW2 - 1) / SW2;
  localparam longint RX3 = (longint'(ACT_W_WIDE) * (longint'(1) << KX) + SW3 - 1) / SW3;
  localparam longint RY0 = (longint'(ACT_H_SHORT) * (longint'(1) << KY) + SH0 - 1) / SH0;
  localparam longint RY1 = (longint'(ACT_H_TALL) * (longint'(1) << KY) + SH1 - 1) / SH1;
  localparam longint RY2 = (longint'(ACT_H_SHORT) * (longint'(1) << KY) + SH2 - 1) / SH2;
  localparam longint RY3 = (longint'(ACT_H_TALL) * (longint'(1) << KY) + SH3 - 1) / SH3;

  localparam int MWX = $clog2(max2(max2(RX0, RX1), max2(RX2, RX3)) + 1);
  localparam int MWY = $clog2(max2(max2(RY0, RY1), max2(RY2, RY3)) + 1);
  localparam int PWX = XW + MWX;
  localparam int PWY = YW + MWY;

  logic [XW-1:0]  sel_sw;
  logic [XW-1:0]  sel_ox;
  logic [YW-1:0]  sel_sh;
  logic [YW-1:0]  sel_oy;
  logic [MWX-1:0] sel_rx;
  logic [MWY-1:0] sel_ry;
  logic [XW-1:0]  x_ext;
  logic [YW-1:0]  y_ext;
  logic [XW-1:0]  rx;
  logic [YW-1:0]  ry;
  logic           in_box;

  logic               va;
  logic               op_a;
  logic [COORD_W-1:0] col_a;
  logic [COORD_W-1:0] row_a;
  logic [PIX_W-1:0]   wdata_a;
  logic               inside_a;
  logic [PWX-1:0]     px_a;
  logic [PWY-1:0]     py_a;

  logic               vb;
  lbs_req_t           req_next;
  logic               ld_a;
  logic               ld_b;
  logic [SX_W-1:0]    sx;
  logic [LINE_W-1:0]  sy;
  logic [LINE_W-1:0]  line;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_ok;

  always_comb begin
    unique case ({wide_mode, tall_mode})
      2'b00: begin
        sel_sw = XW'(SW0); sel_ox = XW'(OX0); sel_rx = MWX'(RX0);
        sel_sh = YW'(SH0); sel_oy = YW'(OY0); sel_ry = MWY'(RY0);
      end
      2'b01: begin
        sel_sw = XW'(SW1); sel_ox = XW'(OX1); sel_rx = MWX'(RX1);
        sel_sh = YW'(SH1); sel_oy = YW'(OY1); sel_ry = MWY'(RY1);
      end
      2'b10: begin
        sel_sw = XW'(SW2); sel_ox = XW'(OX2); sel_rx = MWX'(RX2);
        sel_sh = YW'(SH2); sel_oy = YW'(OY2); sel_ry = MWY'(RY2);
      end
      default: begin
        sel_sw = XW'(SW3); sel_ox = XW'(OX3); sel_rx = MWX'(RX3);
        sel_sh = YW'(SH3); sel_oy = YW'(OY3); sel_ry = MWY'(RY3);
      end
    endcase
  end

  assign x_ext  = XW'(col);
  assign y_ext  = YW'(row);
  assign rx     = x_ext - sel_ox;
  assign ry     = y_ext - sel_oy;
  assign in_box = (x_ext >= sel_ox) && (y_ext >= sel_oy) && (rx < sel_sw) && (ry < sel_sh);

  assign ld_b     = !vb || req_ready;
  assign ld_a     = !va || ld_b;
  assign in_ready = ld_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ld_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a && in_valid) begin
      op_a     <= op;
      col_a    <= col;
      row_a    <= row;
      wdata_a  <= {red[7:3], green[7:2], blue[7:3]};
      inside_a <= in_box;
      px_a     <= PWX'(rx) * PWX'(sel_rx);
      py_a     <= PWY'(ry) * PWY'(sel_ry);
    end
  end

  assign sx      = px_a[KX +: SX_W];
  assign sy      = py_a[KY +: LINE_W];
  assign line    = sy + (tall_mode ? LINE_W'(TOP_TALL) : LINE_W'(TOP_SHORT));
  assign rd_addr = ADDR_W'(line) * ADDR_W'(SRC_W) + ADDR_W'(sx);
  assign wr_addr = ADDR_W'(row_a) * ADDR_W'(SRC_W) + ADDR_W'(col_a);
  assign wr_ok   = (col_a < COORD_W'(SRC_W)) && (row_a < COORD_W'(SRC_H));

  always_comb begin
    req_next.is_read = (op_a == OP_READ);
    req_next.active  = (op_a == OP_READ) ? inside_a : wr_ok;
    req_next.addr    = (op_a == OP_READ) ? rd_addr : wr_addr;
    req_next.wdata   = wdata_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ld_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_b && va) begin
      req <= req_next;
    end
  end

  assign req_valid = vb;

endmodule

// ----- rtl/core/lbs_store.sv -----
// ----------------------------------------------------------------------------
// lbs_store
// Frame store: one synchronous RAM, written by write items and read by read
// items, with the registered read data acting as the result register.
// ----------------------------------------------------------------------------
module lbs_store
  import lbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  lbs_req_t         req,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] pixel
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata;
  logic             zero_q;
  logic             ov;
  logic             ld_o;
  logic             fire;

  assign ld_o      = !ov || out_ready;
  assign req_ready = !req.is_read || ld_o;
  assign fire      = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (fire && !req.is_read && req.active) begin
      mem[req.addr] <= req.wdata;
    end
    if (fire && req.is_read && req.active) begin
      rdata <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && req.is_read) begin
      zero_q <= !req.active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ld_o) begin
      ov <= fire && req.is_read;
    end
  end

  assign out_valid = ov;
  assign pixel     = zero_q ? '0 : rdata;

endmodule

// ----- rtl/core/letterbox_scaler_rgb565.sv -----
// ----------------------------------------------------------------------------
// letterbox_scaler_rgb565
// 320x240 RGB565 frame store with nearest-neighbor, aspect-kept, letterboxed
// read-out onto an OUT_W x OUT_H screen.
// ----------------------------------------------------------------------------
// Sustains one item per clock unless out_ready holds off a result, writes
// and reads mixed freely. A read item's pixel passes the border test and
// reciprocal multiply register, the address register and the frame store RAM
// read register. The frame store is a single 76800x16 RAM with one access per
// cycle, accessed in item order, so a read always sees every earlier write.
// There is no clearing pass; entries hold nothing defined until written. The
// user must write mode registers only with the block idle; nothing enforces it.
module letterbox_scaler_rgb565
  import lbs_pkg::*;
#(
  parameter int OUT_W = OUT_W_DEFAULT,
  parameter int OUT_H = OUT_H_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [COORD_W-1:0]    col,
  input  logic [COORD_W-1:0]    row,
  input  logic [COLOR_W-1:0]    red,
  input  logic [COLOR_W-1:0]    green,
  input  logic [COLOR_W-1:0]    blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      pixel
);

  logic     wide_mode;
  logic     tall_mode;
  logic     req_valid;
  logic     req_ready;
  lbs_req_t req;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b1;
      tall_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDE: wide_mode <= cfg_data[0];
        CFG_TALL: tall_mode <= cfg_data[0];
      endcase
    end
  end

  lbs_map #(
    .OUT_W(OUT_W),
    .OUT_H(OUT_H)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .wide_mode(wide_mode),
    .tall_mode(tall_mode),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .col      (col),
    .row      (row),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req)
  );

  lbs_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel    (pixel)
  );

endmodule

// ----- rtl/core/lbs_checker.sv -----
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level checks of the letterbox scaler, bound to the top level.
// ----------------------------------------------------------------------------
module lbs_checker
  import lbs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] pixel
);

  // a waiting result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // after reset no item can reach the output before passing the pipeline registers
  a_first_latency: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result too early after reset");

  // the pipeline only stalls behind a blocked result
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with output free");

endmodule

bind letterbox_scaler_rgb565 lbs_checker u_chk (.*);

// ----- tb/sv/tb_letterbox_scaler_rgb565.sv -----
// ----------------------------------------------------------------------------
// tb_letterbox_scaler_rgb565
// Checks frame store writes and letterboxed, nearest-neighbor screen reads in
// all four size modes. Random idle gaps on both sides, a long output stall,
// and a predictor that tracks the store contents and the mode registers.
// ----------------------------------------------------------------------------
module tb_letterbox_scaler_rgb565;
  import lbs_pkg::*;

  localparam int SCREEN_W    = OUT_W_DEFAULT;
  localparam int SCREEN_H    = OUT_H_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 200;

  typedef struct {
    logic               op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pix_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WIDE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  op = OP_WRITE;
  logic [COORD_W-1:0]    col = '0;
  logic [COORD_W-1:0]    row = '0;
  logic [COLOR_W-1:0]    red = '0;
  logic [COLOR_W-1:0]    green = '0;
  logic [COLOR_W-1:0]    blue = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      pixel;

  pix_item_t        pending_items[$];
  logic [PIX_W-1:0] expected_pixels[$];
  logic [PIX_W-1:0] stored_pixels[DEPTH];
  bit               written_map[DEPTH];
  bit               mode_wide = 1'b1;
  bit               mode_tall = 1'b0;
  bit               no_idle = 1'b0;
  int               send_gap = 0;
  int               recv_wait = 0;
  int               results_seen = 0;
  int               fail_count = 0;
  int               idle_cycles = 0;

  letterbox_scaler_rgb565 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .col       (col),
    .row       (row),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel     (pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // store index behind a screen pixel, -1 in the border
  function automatic int screen_to_source(int x, int y, bit wide, bit tall);
    int aw, ah, top, sw, sh, ox, oy, rx, ry, sx, sy;
    aw  = wide ? ACT_W_WIDE : ACT_W_NARROW;
    ah  = tall ? ACT_H_TALL : ACT_H_SHORT;
    top = (SRC_H - ah) / 2;
    sw  = aw * SCREEN_H / ah;
    if (sw > SCREEN_W) sw = SCREEN_W;
    sh = sw * ah / aw;
    if (sw == 0 || sh == 0) return -1;
    ox = (SCREEN_W - sw) / 2;
    oy = (SCREEN_H - sh) / 2;
    if (x < ox || y < oy) return -1;
    rx = x - ox;
    ry = y - oy;
    if (rx >= sw || ry >= sh) return -1;
    sx = rx * aw / sw;
    sy = ry * ah / sh;
    if (sx >= SRC_W || top + sy >= SRC_H) return -1;
    return (top + sy) * SRC_W + sx;
  endfunction

  function automatic void track_item(logic o, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
                                     logic [COLOR_W-1:0] rd, logic [COLOR_W-1:0] g,
                                     logic [COLOR_W-1:0] b);
    int idx;
    if (o == OP_WRITE) begin
      if (c < SRC_W && r < SRC_H) stored_pixels[r * SRC_W + c] = {rd[7:3], g[7:2], b[7:3]};
    end else begin
      idx = screen_to_source(int'(c), int'(r), mode_wide, mode_tall);
      expected_pixels.push_back(idx < 0 ? '0 : stored_pixels[idx]);
    end
  endfunction

  task automatic push_write(int c, int r, int rd, int g, int b);
    pix_item_t it;
    it = '{OP_WRITE, COORD_W'(c), COORD_W'(r), COLOR_W'(rd), COLOR_W'(g), COLOR_W'(b)};
    pending_items.push_back(it);
    if (c < SRC_W && r < SRC_H) written_map[r * SRC_W + c] = 1'b1;
  endtask

  // a read never lands on a store entry that was not written first
  task automatic push_read(int x, int y);
    pix_item_t it;
    int idx;
    idx = screen_to_source(x, y, mode_wide, mode_tall);
    if (idx >= 0 && !written_map[idx])
      push_write(idx % SRC_W, idx / SRC_W, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255));
    it = '{OP_READ, COORD_W'(x), COORD_W'(y), COLOR_W'($urandom_range(0, 255)),
           COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255))};
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0);
    // trailing writes may still be in the pipeline
    repeat (6) @(negedge clk);
  endtask

  task automatic set_mode(bit wide, bit tall);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDE;
    cfg_data  <= wide;
    @(posedge clk);
    cfg_index <= CFG_TALL;
    cfg_data  <= tall;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_wide = wide;
    mode_tall = tall;
  endtask

  task automatic run_random(int n, int pause_at);
    int k, x0, y0;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) wait_drained();
      if (i % 50 == 0) begin
        while (pending_items.size() > 8) @(negedge clk);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      k = $urandom_range(0, 99);
      if (k < 40) begin
        push_read($urandom_range(0, SCREEN_W - 1), $urandom_range(0, SCREEN_H - 1));
      end else if (k < 65) begin
        push_write($urandom_range(0, SRC_W - 1), $urandom_range(0, SRC_H - 1),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (k < 75) begin
        push_write($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (k < 85) begin
        push_read($urandom_range(0, 511), $urandom_range(0, 511));
      end else begin
        // short run along one screen line
        x0 = $urandom_range(0, SCREEN_W - 8);
        y0 = $urandom_range(0, SCREEN_H - 1);
        for (int j = 0; j < 8; j++) push_read(x0 + j, y0);
      end
    end
  endtask

  always @(posedge clk) begin : drive_items
    pix_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) track_item(op, col, row, red, green, blue);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          op       <= nxt.op;
          col      <= nxt.col;
          row      <= nxt.row;
          red      <= nxt.red;
          green    <= nxt.green;
          blue     <= nxt.blue;
          in_valid <= 1'b1;
          // keep pushing while the output side is held off
          send_gap <= (no_idle || recv_wait > 8) ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic [PIX_W-1:0] want;
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = (recv_wait > 0) ? recv_wait - 1 : 0;
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected item: pixel %h", pixel);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel !== want) begin
            $error("pixel: expected %h, got %h", want, pixel);
            fail_count++;
          end
        end
        results_seen++;
        if (results_seen == 250) w = LONG_HOLD;
        else w = no_idle ? 0 : $urandom_range(0, 7);
      end
      recv_wait <= w;
      out_ready <= (w == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // store corners, extreme colors, writes past the store
    push_write(0, 0, 0, 0, 0);
    push_write(SRC_W - 1, SRC_H - 1, 255, 255, 255);
    push_write(0, SRC_H - 1, 255, 0, 0);
    push_write(SRC_W - 1, 0, 0, 255, 0);
    push_write(160, 120, 0, 0, 255);
    push_write(SRC_W, 0, 255, 255, 255);
    push_write(0, SRC_H, 255, 255, 255);
    push_write(511, 511, 255, 255, 255);
    // border, screen edges, past the screen, first and last active pixels
    push_read(0, 0);
    push_read(SCREEN_W - 1, SCREEN_H - 1);
    push_read(511, 511);
    push_read(10, 0);
    push_read(11, 0);
    push_read(467, 318);
    push_read(468, 318);
    push_read(467, 319);
    push_read(240, 160);
    push_read(SCREEN_W - 1, 0);
    push_read(0, SCREEN_H - 1);
    push_read(SCREEN_W, 100);
    push_read(100, SCREEN_H);
    run_random(90, -1);

    set_mode(1'b0, 1'b0);
    push_read(57, 0);
    push_read(56, 0);
    push_read(421, 318);
    push_read(422, 318);
    run_random(90, 45);

    set_mode(1'b1, 1'b1);
    push_read(27, 0);
    push_read(452, 318);
    push_read(453, 318);
    run_random(90, -1);

    set_mode(1'b0, 1'b1);
    push_read(69, 0);
    push_read(68, 0);
    push_read(409, 318);
    push_read(410, 318);
    run_random(90, -1);

    set_mode(1'b1, 1'b0);
    run_random(90, -1);

    wait_drained();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
